### src/msd_pkg.sv
package msd_pkg;

    // field widths
    localparam int AXIS_W    = 16;
    localparam int DZ_W      = 15;
    localparam int NUM_W     = 26;
    localparam int TICK_W    = 10;
    localparam int WHEELS    = 4;
    localparam int WHEEL_W   = 2;
    localparam int MAG_W     = 17;
    localparam int CMD_W     = 18;
    localparam int PERIOD_W  = 18;
    localparam int ACC_W     = 19;
    localparam int CFG_W     = 26;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 80;

    // divider sizing
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 5;
    localparam int DIV_NB_W  = 6;

    // quotient bits per kind of division
    localparam logic [DIV_NB_W-1:0] SCALE_BITS  = DIV_NB_W'(DIV_W);
    localparam logic [DIV_NB_W-1:0] PERIOD_BITS = DIV_NB_W'(NUM_W);
    localparam logic [DIV_NB_W-1:0] MOD_BITS    = DIV_NB_W'(ACC_W);

    // stick full scale, at most 32768
    localparam int AXIS_FULL_SCALE = 32768;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = {PERIOD_W{1'b1}};
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(400);

    // register reset values
    localparam logic [DZ_W-1:0]   RST_DEADZONE  = DZ_W'(1500);
    localparam logic [DZ_W-1:0]   RST_STOP_THR  = DZ_W'(97);
    localparam logic [NUM_W-1:0]  RST_NUMERATOR = NUM_W'(13113850);
    localparam logic [TICK_W-1:0] RST_TICK_US   = TICK_W'(200);
    localparam logic [WHEELS-1:0] RST_REV_MASK  = WHEELS'(12);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADZONE   = 3'd0,
        REG_STOP_THR   = 3'd1,
        REG_NUMERATOR  = 3'd2,
        REG_TICK_US    = 3'd3,
        REG_REV_MASK   = 3'd4
    } cfg_reg_t;

    // input word kinds
    typedef enum logic {
        OP_REPORT = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      dividend;
        logic [PERIOD_W-1:0]   divisor;
        logic [DIV_NB_W-1:0]   nbits;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIV_W-1:0]      quotient;
        logic [PERIOD_W-1:0]   remainder;
    } div_resp_t;

    // mixer result per wheel
    typedef struct packed {
        logic [WHEELS-1:0][MAG_W-1:0] mag;
        logic [WHEELS-1:0]            nonzero;
        logic [WHEELS-1:0]            positive;
    } mix_t;

endpackage

### src/msd_divider.sv
module msd_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  msd_pkg::div_req_t   req,
    output msd_pkg::div_resp_t  resp
);
    import msd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dividend_reg, dividend_next;
    logic [PERIOD_W-1:0]  divisor_reg, divisor_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;

    logic [PERIOD_W:0]    trial;
    logic                 fits;

    // one restoring step: bring down the next dividend bit
    assign trial = {rem_reg, dividend_reg[cnt_reg]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        if (req.start)
        begin
            busy_next     = 1'b1;
            cnt_next      = DIV_CNT_W'(req.nbits - DIV_NB_W'(1));
            dividend_next = req.dividend;
            divisor_next  = req.divisor;
            rem_next      = '0;
            quot_next     = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? PERIOD_W'(trial - {1'b0, divisor_reg}) : trial[PERIOD_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
    end

    assign resp.busy      = busy_reg;
    assign resp.done      = done_reg;
    assign resp.quotient  = quot_reg;
    assign resp.remainder = rem_reg;

endmodule

### src/msd_mixer.sv
module msd_mixer (
    input  logic [msd_pkg::AXIS_W-1:0] left_x,
    input  logic [msd_pkg::AXIS_W-1:0] left_y,
    input  logic [msd_pkg::AXIS_W-1:0] right_x,
    input  logic [msd_pkg::DZ_W-1:0]   deadzone,
    output msd_pkg::mix_t              mix
);
    import msd_pkg::*;

    logic signed [CMD_W-1:0] x_dz, y_dz, r_dz;
    logic signed [CMD_W-1:0] cmd [WHEELS];

    // deadzone: magnitude strictly below the threshold reads as zero
    function automatic logic signed [CMD_W-1:0] dz(input logic [AXIS_W-1:0] v,
                                                   input logic [DZ_W-1:0] thr);
        logic signed [CMD_W-1:0] sv;
        logic [MAG_W-1:0]        av;
        sv = $signed({{(CMD_W-AXIS_W){v[AXIS_W-1]}}, v});
        av = sv[CMD_W-1] ? MAG_W'(-sv) : MAG_W'(sv);
        return (av < MAG_W'(thr)) ? '0 : sv;
    endfunction

    assign x_dz = dz(left_x, deadzone);
    assign y_dz = dz(left_y, deadzone);
    assign r_dz = dz(right_x, deadzone);

    // wheel mix: front left, rear left, rear right, front right
    assign cmd[0] = y_dz - x_dz - r_dz;
    assign cmd[1] = y_dz + x_dz - r_dz;
    assign cmd[2] = y_dz - x_dz + r_dz;
    assign cmd[3] = y_dz + x_dz + r_dz;

    // magnitude and sign per wheel
    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            mix.mag[i]      = cmd[i][CMD_W-1] ? MAG_W'(-cmd[i]) : MAG_W'(cmd[i]);
            mix.nonzero[i]  = cmd[i] != '0;
            mix.positive[i] = !cmd[i][CMD_W-1] && (cmd[i] != '0);
        end
    end

endmodule

### src/mecanum_stepper_drive_top.sv
// the time of a report grows when the mix is scaled to full scale;
// the time of a tick depends on how many wheels wrap their accumulator
// throughput: one word at a time, the next is taken once the result is registered;
// the time is set by the radix-2 divider (one quotient bit per cycle) shared by all wheels
// reset: asynchronous, active low; registers take their defaults, periods 400,
// accumulators, step pins and direction pins zero
module mecanum_stepper_drive_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msd_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msd_pkg::S_DATA_W-1:0]  s_tdata,  // left_x, left_y, right_x
    input  logic                          s_tuser,  // operation
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msd_pkg::M_DATA_W-1:0]  m_tdata   // step_pins, dir_pins, period_front_left,
                                                    // period_rear_left, period_rear_right,
                                                    // period_front_right
);
    import msd_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE        = 10'b0000000001,
        S_MIX         = 10'b0000000010,
        S_TOP         = 10'b0000000100,
        S_SCALE       = 10'b0000001000,
        S_SCALE_WAIT  = 10'b0000010000,
        S_PERIOD      = 10'b0000100000,
        S_PERIOD_WAIT = 10'b0001000000,
        S_TICK        = 10'b0010000000,
        S_TICK_WAIT   = 10'b0100000000,
        S_DONE        = 10'b1000000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [WHEEL_W-1:0]            wheel_reg, wheel_next;

    // configuration
    logic [DZ_W-1:0]               deadzone_reg;
    logic [DZ_W-1:0]               stop_thr_reg;
    logic [NUM_W-1:0]              numerator_reg;
    logic [TICK_W-1:0]             tick_us_reg;
    logic [WHEELS-1:0]             rev_mask_reg;

    // wheel state
    logic [WHEELS-1:0][PERIOD_W-1:0] period_reg, period_next;
    logic [WHEELS-1:0][ACC_W-1:0]    accum_reg, accum_next;
    logic [WHEELS-1:0]               step_reg, step_next;
    logic [WHEELS-1:0]               dir_reg, dir_next;
    logic [WHEELS-1:0]               dirpin_reg, dirpin_next;

    // working registers
    logic [S_DATA_W-1:0]             axes_reg, axes_next;
    logic [WHEELS-1:0][MAG_W-1:0]    mag_reg, mag_next;
    logic [MAG_W-1:0]                top_reg, top_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]             out_data_reg, out_data_next;

    mix_t                            mix;
    div_req_t                        div_req;
    div_resp_t                       div_resp;

    logic [MAG_W-1:0]                max01, max23, max_all;
    logic [MAG_W-1:0]                cur_mag;
    logic [PERIOD_W-1:0]             cur_period;
    logic [ACC_W-1:0]                acc_sum;
    logic                            mag_stop;
    logic                            last_wheel;
    logic [PERIOD_W-1:0]             sat_period;

    msd_mixer u_mixer (
        .left_x   (axes_reg[AXIS_W-1:0]),
        .left_y   (axes_reg[2*AXIS_W-1:AXIS_W]),
        .right_x  (axes_reg[3*AXIS_W-1:2*AXIS_W]),
        .deadzone (deadzone_reg),
        .mix      (mix)
    );

    msd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // largest wheel magnitude
    assign max01   = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign max23   = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
    assign max_all = (max01 > max23) ? max01 : max23;

    // current wheel operands
    assign cur_mag    = mag_reg[wheel_reg];
    assign cur_period = period_reg[wheel_reg];
    assign acc_sum    = ACC_W'(accum_reg[wheel_reg] + ACC_W'(tick_us_reg));
    assign mag_stop   = (cur_mag == '0) || (cur_mag < MAG_W'(stop_thr_reg));
    assign last_wheel = wheel_reg == WHEEL_W'(WHEELS - 1);
    assign sat_period = (div_resp.quotient > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                                  : PERIOD_W'(div_resp.quotient);

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        wheel_next     = wheel_reg;
        period_next    = period_reg;
        accum_next     = accum_reg;
        step_next      = step_reg;
        dir_next       = dir_reg;
        dirpin_next    = dirpin_reg;
        axes_next      = axes_reg;
        mag_next       = mag_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        div_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                wheel_next = '0;
                if (s_tvalid)
                begin
                    axes_next  = s_tdata;
                    state_next = (op_t'(s_tuser) == OP_TICK) ? S_TICK : S_MIX;
                end
            end

            S_MIX:
            begin
                mag_next = mix.mag;
                for (int i = 0; i < WHEELS; i++)
                begin
                    if (mix.nonzero[i])
                    begin
                        dir_next[i] = mix.positive[i] == rev_mask_reg[i];
                    end
                end
                state_next = S_TOP;
            end

            S_TOP:
            begin
                top_next   = max_all;
                wheel_next = '0;
                state_next = (max_all > MAG_W'(AXIS_FULL_SCALE)) ? S_SCALE : S_PERIOD;
            end

            S_SCALE:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(cur_mag) * DIV_W'(AXIS_FULL_SCALE);
                div_req.divisor  = PERIOD_W'(top_reg);
                div_req.nbits    = SCALE_BITS;
                state_next       = S_SCALE_WAIT;
            end

            S_SCALE_WAIT:
            begin
                if (div_resp.done)
                begin
                    mag_next[wheel_reg] = MAG_W'(div_resp.quotient);
                    wheel_next          = wheel_reg + WHEEL_W'(1);
                    state_next          = last_wheel ? S_PERIOD : S_SCALE;
                end
            end

            S_PERIOD:
            begin
                if (mag_stop)
                begin
                    period_next[wheel_reg] = '0;
                    wheel_next             = wheel_reg + WHEEL_W'(1);
                    state_next             = last_wheel ? S_DONE : S_PERIOD;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(numerator_reg);
                    div_req.divisor  = PERIOD_W'(cur_mag);
                    div_req.nbits    = PERIOD_BITS;
                    state_next       = S_PERIOD_WAIT;
                end
            end

            S_PERIOD_WAIT:
            begin
                if (div_resp.done)
                begin
                    period_next[wheel_reg] = sat_period;
                    wheel_next             = wheel_reg + WHEEL_W'(1);
                    state_next             = last_wheel ? S_DONE : S_PERIOD;
                end
            end

            S_TICK:
            begin
                if (cur_period == '0)
                begin
                    wheel_next = wheel_reg + WHEEL_W'(1);
                    state_next = last_wheel ? S_DONE : S_TICK;
                end
                else if (acc_sum > ACC_W'(cur_period))
                begin
                    // toggle, latch direction, then wrap the accumulator
                    step_next[wheel_reg]   = !step_reg[wheel_reg];
                    dirpin_next[wheel_reg] = dir_reg[wheel_reg];
                    div_req.start          = 1'b1;
                    div_req.dividend       = DIV_W'(acc_sum);
                    div_req.divisor        = cur_period;
                    div_req.nbits          = MOD_BITS;
                    state_next             = S_TICK_WAIT;
                end
                else
                begin
                    accum_next[wheel_reg] = acc_sum;
                    wheel_next            = wheel_reg + WHEEL_W'(1);
                    state_next            = last_wheel ? S_DONE : S_TICK;
                end
            end

            S_TICK_WAIT:
            begin
                if (div_resp.done)
                begin
                    accum_next[wheel_reg] = ACC_W'(div_resp.remainder);
                    wheel_next            = wheel_reg + WHEEL_W'(1);
                    state_next            = last_wheel ? S_DONE : S_TICK;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {period_reg[3], period_reg[2], period_reg[1],
                                      period_reg[0], dirpin_reg, step_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= RST_DEADZONE;
            stop_thr_reg  <= RST_STOP_THR;
            numerator_reg <= RST_NUMERATOR;
            tick_us_reg   <= RST_TICK_US;
            rev_mask_reg  <= RST_REV_MASK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEADZONE:  deadzone_reg  <= cfg_data[DZ_W-1:0];
                REG_STOP_THR:  stop_thr_reg  <= cfg_data[DZ_W-1:0];
                REG_NUMERATOR: numerator_reg <= cfg_data[NUM_W-1:0];
                REG_TICK_US:   tick_us_reg   <= cfg_data[TICK_W-1:0];
                REG_REV_MASK:  rev_mask_reg  <= cfg_data[WHEELS-1:0];
                default:       ;
            endcase
        end
    end

    // control and wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wheel_reg     <= '0;
            period_reg    <= {WHEELS{RESET_PERIOD}};
            accum_reg     <= '0;
            step_reg      <= '0;
            dir_reg       <= '0;
            dirpin_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            period_reg    <= period_next;
            accum_reg     <= accum_next;
            step_reg      <= step_next;
            dir_reg       <= dir_next;
            dirpin_reg    <= dirpin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output data
    always_ff @(posedge clk)
    begin
        axes_reg     <= axes_next;
        mag_reg      <= mag_next;
        top_reg      <= top_next;
        out_data_reg <= out_data_next;
    end

    // the shared divider is idle whenever a new word can be taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_resp.busy)
        else $error("divider busy while accepting a word");

    // a division finishes only while the sequencer waits for it
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_resp.done |-> (state_reg == S_SCALE_WAIT || state_reg == S_PERIOD_WAIT ||
                           state_reg == S_TICK_WAIT))
        else $error("divider result with no sequencer waiting");

    // an accepted word blocks the input until its result is out
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in progress");

    // a new result appears only after the finishing step
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside the finishing step");

endmodule
